@@ rtl/bdlp_pkg.sv @@
package bdlp_pkg;

  localparam int KeysW    = 4;
  localparam int SecsW    = 6;
  localparam int MaskW    = 4;
  localparam int ThreshW  = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;

  // buttons that own a config slot and a key pin
  localparam int CfgButtons = 4;

  localparam int PressCount   = 3;
  localparam int ReleaseCount = 3;
  localparam int SecsPerMin   = 60;

  localparam logic [CfgIdxW-1:0] RegPressEnable = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLongSecsA   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLongSecsB   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLongSecsC   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLongSecsD   = 3'd4;

  localparam logic [ThreshW-1:0] LongSecsDReset = 8'd2;

  typedef struct packed {
    logic [KeysW-1:0] keys_raw;
    logic [SecsW-1:0] secs_now;
    logic             scan_all;
  } in_item_t;

  typedef struct packed {
    logic [MaskW-1:0] press_events;
    logic [MaskW-1:0] long_events;
    logic [MaskW-1:0] held_mask;
  } out_item_t;

  typedef struct packed {
    logic step;
    logic pressed;
    logic press_en;
  } btn_ctrl_t;

  typedef struct packed {
    logic press_ev;
    logic long_ev;
    logic held;
  } btn_stat_t;

endpackage

@@ rtl/bdlp_in_if.sv @@
interface bdlp_in_if;
  import bdlp_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/bdlp_out_if.sv @@
interface bdlp_out_if;
  import bdlp_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/button_debounce_long_press.sv @@
// Debounces NUM_BUTTONS active-low keys, one sample tick per input beat (only
// the last button if scan_all is low), and gives one result beat per tick with
// press events, long-press events and the held mask. Each button shifts its
// level into a HISTORY_BITS history; a pressed sample with three or more ones
// latches a press, a released one with at most three ends it. Long presses
// compare seconds elapsed since the latched press second against a per-button
// threshold, at most one long event per second across all buttons. Throughput
// is one beat per clock: a beat is registered on input and again on output, and
// a stalled result only stops intake once the input register is also full.
// Configuration registers, written through cfg_we_i, apply from the next tick.
module button_debounce_long_press #(
  parameter int NUM_BUTTONS  = 4,
  parameter int HISTORY_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bdlp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bdlp_pkg::CfgDataW-1:0] cfg_data_i,
  bdlp_in_if.sink                       item_i,
  bdlp_out_if.source                    result_o
);
  import bdlp_pkg::*;

  logic [CfgButtons-1:0]              press_enable;
  logic [CfgButtons-1:0][ThreshW-1:0] long_secs;

  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t result;
  logic      adv;

  logic [NUM_BUTTONS:0][ThreshW-1:0] last_chain;
  logic [ThreshW-1:0]                last_long_q;
  btn_stat_t [NUM_BUTTONS-1:0]       stat;

  bdlp_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .press_enable_o (press_enable),
    .long_secs_o    (long_secs)
  );

  assign adv          = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      in_q <= item_i.data;
    end
  end

  assign last_chain[0] = last_long_q;

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
    btn_ctrl_t          ctrl;
    logic [ThreshW-1:0] thresh;
    logic               scanned;

    assign scanned = in_q.scan_all || (b == NUM_BUTTONS - 1);
    if (b < CfgButtons) begin : g_cfg
      assign ctrl.pressed  = !in_q.keys_raw[b];
      assign ctrl.press_en = press_enable[b];
      assign thresh        = long_secs[b];
    end else begin : g_extra
      // no pin and no config slot: reads as pressed, never enabled
      assign ctrl.pressed  = 1'b1;
      assign ctrl.press_en = 1'b0;
      assign thresh        = '0;
    end
    assign ctrl.step = adv && scanned;

    bdlp_btn #(
      .HistBits (HISTORY_BITS)
    ) u_btn (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .secs_i      (in_q.secs_now),
      .thresh_i    (thresh),
      .last_long_i (last_chain[b]),
      .last_long_o (last_chain[b+1]),
      .stat_o      (stat[b])
    );
  end

  for (genvar i = 0; i < MaskW; i++) begin : g_out
    if (i < NUM_BUTTONS) begin : g_on
      assign result.press_events[i] = stat[i].press_ev;
      assign result.long_events[i]  = stat[i].long_ev;
      assign result.held_mask[i]    = stat[i].held;
    end else begin : g_off
      assign result.press_events[i] = 1'b0;
      assign result.long_events[i]  = 1'b0;
      assign result.held_mask[i]    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_long_q <= '0;
    end else begin
      if (adv) begin
        out_valid_q <= 1'b1;
        last_long_q <= last_chain[NUM_BUTTONS];
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= result;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

`ifndef NO_ASSERTIONS
  a_long_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0(out_q.long_events))
    else $error("more than one long event in a beat");

  a_press_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.press_events & ~out_q.held_mask) == '0))
    else $error("press event on a button that is not held");

  a_last_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (result.long_events != '0))
      |=> (last_long_q == ThreshW'($past(in_q.secs_now))))
    else $error("last long second not updated after a long event");
`endif

endmodule

@@ rtl/bdlp_cfg.sv @@
module bdlp_cfg (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [bdlp_pkg::CfgIdxW-1:0]              cfg_idx_i,
  input  logic [bdlp_pkg::CfgDataW-1:0]             cfg_data_i,
  output logic [bdlp_pkg::CfgButtons-1:0]           press_enable_o,
  output logic [bdlp_pkg::CfgButtons-1:0][bdlp_pkg::ThreshW-1:0] long_secs_o
);
  import bdlp_pkg::*;

  logic [CfgButtons-1:0]              press_enable_q;
  logic [CfgButtons-1:0][ThreshW-1:0] long_secs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_enable_q <= '0;
      // only the last button starts with a threshold
      long_secs_q    <= {LongSecsDReset, {((CfgButtons - 1) * ThreshW){1'b0}}};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPressEnable: press_enable_q <= cfg_data_i[CfgButtons-1:0];
        RegLongSecsA:   long_secs_q[0] <= cfg_data_i[ThreshW-1:0];
        RegLongSecsB:   long_secs_q[1] <= cfg_data_i[ThreshW-1:0];
        RegLongSecsC:   long_secs_q[2] <= cfg_data_i[ThreshW-1:0];
        RegLongSecsD:   long_secs_q[3] <= cfg_data_i[ThreshW-1:0];
        default: ;
      endcase
    end
  end

  assign press_enable_o = press_enable_q;
  assign long_secs_o    = long_secs_q;

endmodule

@@ rtl/bdlp_btn.sv @@
module bdlp_btn #(
  parameter int HistBits = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bdlp_pkg::btn_ctrl_t           ctrl_i,
  input  logic [bdlp_pkg::SecsW-1:0]    secs_i,
  input  logic [bdlp_pkg::ThreshW-1:0]  thresh_i,
  input  logic [bdlp_pkg::ThreshW-1:0]  last_long_i,
  output logic [bdlp_pkg::ThreshW-1:0]  last_long_o,
  output bdlp_pkg::btn_stat_t           stat_o
);
  import bdlp_pkg::*;

  localparam int CntMax = (HistBits > 8) ? HistBits : 8;
  localparam int CntW   = $clog2(CntMax + 1);
  localparam int DiffW  = SecsW + 2;
  localparam logic [CntW-1:0] PressCnt   = CntW'(PressCount);
  localparam logic [CntW-1:0] ReleaseCnt = CntW'(ReleaseCount);

  logic [HistBits-1:0] hist_q, hist_d;
  logic                latched_q, latched_d;
  logic                done_q, done_d;
  logic [SecsW-1:0]    ps_q, ps_d;
  logic [CntW-1:0]     cnt;
  logic signed [DiffW-1:0] diff;
  logic [SecsW-1:0]    elapsed;
  logic                press_ev, long_ev;

  always_comb begin
    hist_d    = {hist_q[HistBits-2:0], ctrl_i.pressed};
    cnt       = CntW'($countones(hist_d));
    latched_d = latched_q;
    done_d    = done_q;
    ps_d      = ps_q;
    press_ev  = 1'b0;
    long_ev   = 1'b0;
    diff      = '0;
    elapsed   = '0;

    if (ctrl_i.pressed) begin
      if (cnt >= PressCnt) begin
        if (!latched_q) begin
          ps_d      = secs_i;
          latched_d = 1'b1;
        end
        if (!done_q && ctrl_i.press_en) begin
          done_d   = 1'b1;
          press_ev = 1'b1;
        end
      end
      // elapsed seconds against the (possibly just latched) press second
      if (cnt > ReleaseCnt) begin
        diff = $signed({2'b00, secs_i}) - $signed({2'b00, ps_d});
        if (diff < 0) diff = diff + DiffW'(SecsPerMin);
        elapsed = (diff < 0) ? '0 : diff[SecsW-1:0];
      end
      long_ev = (thresh_i != '0) && (ThreshW'(elapsed) >= thresh_i)
                && (ThreshW'(secs_i) != last_long_i);
    end else if (cnt <= ReleaseCnt) begin
      latched_d = 1'b0;
      done_d    = 1'b0;
      ps_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q    <= '0;
      latched_q <= 1'b0;
      done_q    <= 1'b0;
      ps_q      <= '0;
    end else if (ctrl_i.step) begin
      hist_q    <= hist_d;
      latched_q <= latched_d;
      done_q    <= done_d;
      ps_q      <= ps_d;
    end
  end

  // shared last-second value ripples through the buttons in order
  assign last_long_o     = (ctrl_i.step && long_ev) ? ThreshW'(secs_i) : last_long_i;
  assign stat_o.press_ev = ctrl_i.step && press_ev;
  assign stat_o.long_ev  = ctrl_i.step && long_ev;
  assign stat_o.held     = ctrl_i.step ? latched_d : latched_q;

endmodule

@@ tb/sv/bdlp_checker.sv @@
module bdlp_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bdlp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bdlp_pkg::CfgDataW-1:0] cfg_data_i,
  bdlp_in_if                            item_i,
  bdlp_out_if                           result_i,
  output int                            errors_o,
  output int                            outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bdlp_pkg::*;

  localparam int HistBits = 8;

  logic [HistBits-1:0] hist      [CfgButtons];
  bit                  latched   [CfgButtons];
  bit                  done      [CfgButtons];
  logic [SecsW-1:0]    press_sec [CfgButtons];
  logic [ThreshW-1:0]  long_thr  [CfgButtons];
  logic [7:0]          last_long_sec;
  logic [MaskW-1:0]    press_en;

  out_item_t tick_results_q[$];
  out_item_t want;
  int        n_errors = 0;

  // advance the button state by one sample tick and return the tick's result
  function automatic out_item_t debounce_tick(in_item_t it);
    out_item_t r;
    int        lo;
    int        cnt;
    int        el;
    bit        down;
    r  = '0;
    lo = it.scan_all ? 0 : CfgButtons - 1;
    for (int b = lo; b < CfgButtons; b++) begin
      down    = !it.keys_raw[b];
      hist[b] = {hist[b][HistBits-2:0], down};
      cnt     = $countones(hist[b]);
      if (down) begin
        if (cnt >= PressCount) begin
          if (!latched[b]) begin
            press_sec[b] = it.secs_now;
            latched[b]   = 1'b1;
          end
          if (!done[b] && press_en[b]) begin
            done[b]           = 1'b1;
            r.press_events[b] = 1'b1;
          end
        end
        if (long_thr[b] != '0) begin
          el = 0;
          if (cnt > ReleaseCount) begin
            el = int'(it.secs_now) - int'(press_sec[b]);
            if (el < 0) el += SecsPerMin;
            // out-of-range seconds can leave it negative
            if (el < 0) el = 0;
          end
          if (el >= int'(long_thr[b]) && {2'b00, it.secs_now} != last_long_sec) begin
            last_long_sec    = {2'b00, it.secs_now};
            r.long_events[b] = 1'b1;
          end
        end
      end else if (cnt <= ReleaseCount) begin
        latched[b]   = 1'b0;
        done[b]      = 1'b0;
        press_sec[b] = '0;
      end
    end
    for (int b = 0; b < CfgButtons; b++) begin
      r.held_mask[b] = latched[b];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < CfgButtons; b++) begin
        hist[b]      = '0;
        latched[b]   = 1'b0;
        done[b]      = 1'b0;
        press_sec[b] = '0;
        long_thr[b]  = '0;
      end
      long_thr[CfgButtons-1] = LongSecsDReset;
      last_long_sec = '0;
      press_en      = '0;
      tick_results_q.delete();
      outstanding_o <= 0;
      errors_o      <= n_errors;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegPressEnable: press_en    = cfg_data_i[MaskW-1:0];
          RegLongSecsA:   long_thr[0] = cfg_data_i;
          RegLongSecsB:   long_thr[1] = cfg_data_i;
          RegLongSecsC:   long_thr[2] = cfg_data_i;
          RegLongSecsD:   long_thr[3] = cfg_data_i;
          default: ;
        endcase
      end
      if (item_i.valid && item_i.ready) begin
        tick_results_q.push_back(debounce_tick(item_i.data));
      end
      if (result_i.valid && result_i.ready) begin
        if (tick_results_q.size() == 0) begin
          $error("result beat with no tick pending: %h", result_i.data);
          n_errors++;
        end else begin
          want = tick_results_q.pop_front();
          if (result_i.data.press_events !== want.press_events) begin
            $error("press_events: expected %h, got %h",
                   want.press_events, result_i.data.press_events);
            n_errors++;
          end
          if (result_i.data.long_events !== want.long_events) begin
            $error("long_events: expected %h, got %h",
                   want.long_events, result_i.data.long_events);
            n_errors++;
          end
          if (result_i.data.held_mask !== want.held_mask) begin
            $error("held_mask: expected %h, got %h",
                   want.held_mask, result_i.data.held_mask);
            n_errors++;
          end
        end
      end
      outstanding_o <= tick_results_q.size();
      errors_o      <= n_errors;
    end
  end

endmodule

@@ tb/sv/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bdlp_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnusedLo = 3'd5;
  localparam logic [CfgIdxW-1:0] RegUnusedHi = 3'd7;

  localparam int PhaseTicks    = 170;
  localparam int HoldOffCycles = 150;
  localparam int StallLimit    = 1000;
  localparam int SettleCycles  = 8;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  bdlp_in_if  item_if ();
  bdlp_out_if result_if ();

  int n_errors;
  int n_pending;
  int quiet_cycles = 0;

  // stimulus shaping
  bit         src_idle_on;
  bit         sink_idle_on;
  bit         hold_req;
  bit   [3:0] phys_down;
  int         hold_left [CfgButtons];
  logic [5:0] wall_sec;

  always #2ns clk = ~clk;

  button_debounce_long_press i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .item_i     (item_if),
    .result_o   (result_if)
  );

  bdlp_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .item_i        (item_if),
    .result_i      (result_if),
    .errors_o      (n_errors),
    .outstanding_o (n_pending)
  );

  task automatic send_tick(input logic [3:0] keys, input logic [5:0] secs, input logic all);
    in_item_t it;
    it.keys_raw = keys;
    it.secs_now = secs;
    it.scan_all = all;
    while (src_idle_on && $urandom_range(99) < 14) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.data  <= it;
    do @(posedge clk); while (!item_if.ready);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // let every pending tick come out, then give the pipeline time to settle
  task automatic drain();
    item_if.valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // buttons held and released for random spans, with contact bounce and noise
  task automatic random_tick();
    logic [3:0] keys;
    logic [5:0] secs;
    logic       all;
    for (int b = 0; b < CfgButtons; b++) begin
      if (hold_left[b] == 0) begin
        phys_down[b] = ~phys_down[b];
        hold_left[b] = phys_down[b] ? $urandom_range(3, 40) : $urandom_range(1, 12);
      end
      hold_left[b] = hold_left[b] - 1;
      keys[b] = ~phys_down[b] ^ ($urandom_range(99) < 8);
    end
    if ($urandom_range(99) < 35) wall_sec = (wall_sec >= 6'd59) ? 6'd0 : wall_sec + 6'd1;
    secs = wall_sec;
    if ($urandom_range(99) < 10) keys = 4'($urandom());
    if ($urandom_range(99) < 3) secs = 6'($urandom_range(63));
    all = ($urandom_range(99) < 80);
    send_tick(keys, secs, all);
  endtask

  task automatic run_phase(input logic [7:0] pe, input logic [7:0] a, input logic [7:0] b,
                           input logic [7:0] c, input logic [7:0] d,
                           input bit quiet, input bit squeeze);
    drain();
    write_reg(RegPressEnable, pe);
    write_reg(RegLongSecsA, a);
    write_reg(RegLongSecsB, b);
    write_reg(RegLongSecsC, c);
    write_reg(RegLongSecsD, d);
    cfg_we       <= 1'b0;
    src_idle_on  = !quiet;
    sink_idle_on <= !quiet;
    for (int i = 0; i < PhaseTicks; i++) begin
      if (squeeze && i == PhaseTicks / 3) hold_req <= ~hold_req;
      random_tick();
    end
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    bit seen_req;
    int hold;
    seen_req = 1'b0;
    hold     = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != seen_req) begin
        seen_req = hold_req;
        hold     = HoldOffCycles;
      end
      if (hold > 0) begin
        hold = hold - 1;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= !(sink_idle_on && $urandom_range(99) < 14);
      end
    end
  end

  always @(posedge clk) begin
    if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    item_if.valid <= 1'b0;
    item_if.data  <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_data      <= '0;
    src_idle_on   = 1'b1;
    sink_idle_on  <= 1'b1;
    hold_req      <= 1'b0;
    phys_down     = '0;
    wall_sec      = '0;
    for (int b = 0; b < CfgButtons; b++) hold_left[b] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: no press handlers, only the last button has a threshold
    send_tick(4'hF, 6'd0, 1'b1);
    send_tick(4'h0, 6'd0, 1'b1);
    send_tick(4'h0, 6'd0, 1'b0);
    send_tick(4'h0, 6'd0, 1'b1);
    // last button goes long at second two; the shared second blocks a repeat
    send_tick(4'h0, 6'd0, 1'b1);
    send_tick(4'h0, 6'd1, 1'b1);
    send_tick(4'h0, 6'd2, 1'b1);
    send_tick(4'h0, 6'd2, 1'b1);
    send_tick(4'h7, 6'd59, 1'b0);
    send_tick(4'h8, 6'd63, 1'b0);
    send_tick(4'hF, 6'd63, 1'b1);
    send_tick(4'hF, 6'd62, 1'b1);
    drain();

    // writes beyond the register list must not disturb anything
    write_reg(RegUnusedLo, 8'hFF);
    write_reg(RegUnusedHi, 8'hFF);
    write_reg(RegPressEnable, 8'hFF);
    write_reg(RegLongSecsA, 8'd1);
    write_reg(RegLongSecsB, 8'd255);
    write_reg(RegLongSecsC, 8'd128);
    write_reg(RegLongSecsD, 8'd1);
    cfg_we <= 1'b0;
    // out-of-range seconds, elapsed time wrapping and saturating
    send_tick(4'hE, 6'd60, 1'b1);
    send_tick(4'hE, 6'd61, 1'b1);
    send_tick(4'hE, 6'd62, 1'b1);
    send_tick(4'hE, 6'd63, 1'b1);
    send_tick(4'hE, 6'd0, 1'b1);
    send_tick(4'hE, 6'd5, 1'b1);
    send_tick(4'h5, 6'd5, 1'b1);
    send_tick(4'h5, 6'd6, 1'b1);
    send_tick(4'h5, 6'd7, 1'b1);
    send_tick(4'h0, 6'd8, 1'b1);
    send_tick(4'hA, 6'd8, 1'b0);

    run_phase(8'h0F, 8'd1, 8'd2, 8'd3, 8'd4, 1'b0, 1'b0);
    run_phase(8'hF0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
    run_phase(8'h05, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
    run_phase(8'($urandom()), 8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
              8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)), 1'b0, 1'b1);
    run_phase(8'h0A, 8'd2, 8'd0, 8'd6, 8'd1, 1'b0, 1'b0);

    drain();
    if (n_errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bdlp_pkg.sv
rtl/bdlp_in_if.sv
rtl/bdlp_out_if.sv
rtl/bdlp_cfg.sv
rtl/bdlp_btn.sv
rtl/button_debounce_long_press.sv
tb/sv/bdlp_checker.sv
tb/sv/tb.sv
